// ----- hw/rtl/contact_graph_color_allocator_top_defines.svh -----
// Assertion macros shared by the allocator's checker.
`ifndef CONTACT_GRAPH_COLOR_ALLOCATOR_TOP_DEFINES_SVH
`define CONTACT_GRAPH_COLOR_ALLOCATOR_TOP_DEFINES_SVH

// Consequent must hold in the same cycle as the antecedent.
`define CGCA_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define CGCA_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- hw/rtl/cgca_pkg.sv -----
// Package with the sizes, codes and word types of the contact graph color allocator.
`timescale 1ns / 1ps

package cgca_pkg;

  // Sizing of the stores. BODIES and SLOTS are powers of two.
  localparam int COLORS = 12;
  localparam int BODIES = 1024;
  localparam int SLOTS  = 1024;

  // Fixed field widths of the request and response words.
  localparam int BODY_FW   = 10;
  localparam int ID_W      = 16;
  localparam int COLOR_FW  = 4;
  localparam int SLOT_FW   = 10;
  localparam int STATUS_W  = 2;

  // Derived internal widths.
  localparam int COLOR_W = $clog2(COLORS);
  localparam int BODY_AW = $clog2(BODIES);
  localparam int SLOT_AW = $clog2(SLOTS);
  localparam int CNT_W   = $clog2(SLOTS + 1);
  localparam int LIST_DEPTH = COLORS * SLOTS;
  localparam int LIST_AW = $clog2(LIST_DEPTH);

  // Request kinds.
  localparam logic KIND_ADD    = 1'b0;
  localparam logic KIND_REMOVE = 1'b1;

  // Response status codes.
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_NOCOLOR = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL    = 2'd2;

  typedef struct packed {
    logic                kind;
    logic [BODY_FW-1:0]  body_a;
    logic [BODY_FW-1:0]  body_b;
    logic                a_dynamic;
    logic                b_dynamic;
    logic [ID_W-1:0]     contact_id;
    logic [COLOR_FW-1:0] color_in;
    logic [SLOT_FW-1:0]  slot_in;
  } cgca_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [COLOR_FW-1:0] color_out;
    logic [SLOT_FW-1:0]  slot_out;
    logic                moved_valid;
    logic [ID_W-1:0]     moved_contact;
  } cgca_result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clear;   // write one zero mask entry of the clearing pass
    logic accept;  // a request word is taken this cycle
    logic eval;    // search, update counts, first mask write
    logic finish;  // second mask write, list move, load the response
  } ctl_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clear_last;  // clearing pass is at its last entry
    logic out_free;    // response register can take a new word
  } ctl_sts_t;

endpackage

// ----- hw/rtl/cgca_ifs.sv -----
// Handshake interfaces for the request and response channels.
`timescale 1ns / 1ps

interface cgca_req_if;
  logic                   valid;
  logic                   ready;
  cgca_pkg::cgca_item_t   data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface cgca_rsp_if;
  logic                   valid;
  logic                   ready;
  cgca_pkg::cgca_result_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ----- hw/rtl/cgca_ram.sv -----
// Generic single write port RAM with one registered read port.
`timescale 1ns / 1ps

module cgca_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/cgca_dp.sv -----
// Datapath: body mask and list memories, color counts, search and response register.
`timescale 1ns / 1ps

module cgca_dp (
  input  logic                   clk,
  input  logic                   rst,
  input  cgca_pkg::ctl_cmd_t     cmd,
  output cgca_pkg::ctl_sts_t     sts,
  input  cgca_pkg::cgca_item_t   req_data,
  output logic                   rsp_valid,
  input  logic                   rsp_ready,
  output cgca_pkg::cgca_result_t rsp_data
);
  import cgca_pkg::*;

  // Latched request.
  logic                kind_r;
  logic [BODY_AW-1:0]  a_r;
  logic [BODY_AW-1:0]  b_r;
  logic                da_r;
  logic                db_r;
  logic [ID_W-1:0]     id_r;
  logic [COLOR_FW-1:0] col_r;
  logic [SLOT_FW-1:0]  slot_r;

  logic [BODY_AW-1:0]  clr_addr;
  logic [CNT_W-1:0]    counts [COLORS];

  // Memory ports.
  logic [COLORS-1:0]   ma;
  logic [COLORS-1:0]   mb;
  logic                mask_we;
  logic [BODY_AW-1:0]  mask_waddr;
  logic [COLORS-1:0]   mask_wdata;
  logic                list_we;
  logic [LIST_AW-1:0]  list_waddr;
  logic [ID_W-1:0]     list_wdata;
  logic [LIST_AW-1:0]  list_raddr;
  logic [ID_W-1:0]     list_rdata;

  // Evaluation terms.
  logic                any_dyn;
  logic [COLORS-1:0]   need;
  logic                found;
  logic [COLOR_W-1:0]  fc;
  logic [CNT_W-1:0]    fc_cnt;
  logic                add_full;
  logic                add_ok;
  logic                col_ok;
  logic [COLOR_W-1:0]  col_idx;
  logic [CNT_W-1:0]    rm_cnt;
  logic [CNT_W-1:0]    rm_last;
  logic                rm_ok;
  logic                rm_move;
  logic                upd;
  logic [COLOR_W-1:0]  op_col;
  logic [COLORS-1:0]   bit_sel;
  logic [COLORS-1:0]   ma_new;
  logic [COLORS-1:0]   mb_new;
  logic [STATUS_W-1:0] ev_status;
  logic [COLOR_FW-1:0] ev_color;
  logic [SLOT_FW-1:0]  ev_slot;

  // Held between evaluation and finish.
  logic [STATUS_W-1:0] res_status;
  logic [COLOR_FW-1:0] res_color;
  logic [SLOT_FW-1:0]  res_slot;
  logic                mv_pend;
  logic                wb_pend;
  logic [COLORS-1:0]   mb_new_r;

  // Two copies of the body masks so both bodies are read in the same cycle.
  cgca_ram #(.WIDTH(COLORS), .DEPTH(BODIES)) u_mask_a (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (mask_wdata),
    .re    (cmd.accept),
    .raddr (req_data.body_a[BODY_AW-1:0]),
    .rdata (ma)
  );

  cgca_ram #(.WIDTH(COLORS), .DEPTH(BODIES)) u_mask_b (
    .clk   (clk),
    .we    (mask_we),
    .waddr (mask_waddr),
    .wdata (mask_wdata),
    .re    (cmd.accept),
    .raddr (req_data.body_b[BODY_AW-1:0]),
    .rdata (mb)
  );

  cgca_ram #(.WIDTH(ID_W), .DEPTH(LIST_DEPTH)) u_list (
    .clk   (clk),
    .we    (list_we),
    .waddr (list_waddr),
    .wdata (list_wdata),
    .re    (cmd.eval),
    .raddr (list_raddr),
    .rdata (list_rdata)
  );

  // First free color; colors other than 0 only unless both bodies are dynamic.
  always_comb begin
    found = 1'b0;
    fc    = '0;
    for (int i = 0; i < COLORS; i++) begin
      if (!found && !need[i] && (i != 0 || (da_r && db_r))) begin
        found = 1'b1;
        fc    = COLOR_W'(i);
      end
    end
  end

  always_comb begin
    any_dyn  = da_r | db_r;
    need     = (da_r ? ma : '0) | (db_r ? mb : '0);
    fc_cnt   = counts[fc];
    add_full = fc_cnt >= CNT_W'(SLOTS);
    add_ok   = (kind_r == KIND_ADD) && any_dyn && found && !add_full;

    col_ok   = 32'(col_r) < COLORS;
    col_idx  = col_r[COLOR_W-1:0];
    rm_cnt   = col_ok ? counts[col_idx] : '0;
    rm_last  = rm_cnt - CNT_W'(1);
    rm_ok    = (kind_r == KIND_REMOVE) && any_dyn && col_ok && (CNT_W'(slot_r) < rm_cnt);
    rm_move  = CNT_W'(slot_r) < rm_last;

    upd      = add_ok | rm_ok;
    op_col   = (kind_r == KIND_REMOVE) ? col_idx : fc;
    bit_sel  = COLORS'(1) << op_col;
    ma_new   = (kind_r == KIND_REMOVE) ? (ma & ~bit_sel) : (ma | bit_sel);
    mb_new   = (kind_r == KIND_REMOVE) ? (mb & ~bit_sel) : (mb | bit_sel);

    ev_status = ST_NOCOLOR;
    ev_color  = '0;
    ev_slot   = '0;
    if (any_dyn) begin
      if (kind_r == KIND_ADD) begin
        if (found && add_full) begin
          ev_status = ST_FULL;
          ev_color  = COLOR_FW'(fc);
        end else if (found) begin
          ev_status = ST_OK;
          ev_color  = COLOR_FW'(fc);
          ev_slot   = SLOT_FW'(fc_cnt);
        end
      end else if (rm_ok) begin
        ev_status = ST_OK;
      end
    end
  end

  // Mask write port: clearing pass, then body a at evaluation, body b at finish.
  always_comb begin
    mask_we    = 1'b0;
    mask_waddr = a_r;
    mask_wdata = ma_new;
    if (cmd.clear) begin
      mask_we    = 1'b1;
      mask_waddr = clr_addr;
      mask_wdata = '0;
    end else if (cmd.eval) begin
      mask_we    = upd & da_r;
    end else if (cmd.finish) begin
      mask_we    = wb_pend;
      mask_waddr = b_r;
      mask_wdata = mb_new_r;
    end
  end

  // List port: append at evaluation, move the last entry at finish.
  always_comb begin
    list_we    = (cmd.eval & add_ok) | (cmd.finish & mv_pend);
    list_raddr = LIST_AW'({col_idx, rm_last[SLOT_AW-1:0]});
    if (cmd.finish) begin
      list_waddr = LIST_AW'({col_idx, slot_r[SLOT_AW-1:0]});
      list_wdata = list_rdata;
    end else begin
      list_waddr = LIST_AW'({fc, fc_cnt[SLOT_AW-1:0]});
      list_wdata = id_r;
    end
  end

  assign sts.clear_last = clr_addr == BODY_AW'(BODIES - 1);
  assign sts.out_free   = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      kind_r <= req_data.kind;
      a_r    <= req_data.body_a[BODY_AW-1:0];
      b_r    <= req_data.body_b[BODY_AW-1:0];
      da_r   <= req_data.a_dynamic;
      db_r   <= req_data.b_dynamic;
      id_r   <= req_data.contact_id;
      col_r  <= req_data.color_in;
      slot_r <= req_data.slot_in;
    end
    if (cmd.eval) begin
      res_status <= ev_status;
      res_color  <= ev_color;
      res_slot   <= ev_slot;
      mv_pend    <= rm_ok & rm_move;
      wb_pend    <= upd & db_r;
      mb_new_r   <= mb_new;
    end
    if (cmd.finish) begin
      rsp_data.status        <= res_status;
      rsp_data.color_out     <= res_color;
      rsp_data.slot_out      <= res_slot;
      rsp_data.moved_valid   <= mv_pend;
      rsp_data.moved_contact <= mv_pend ? list_rdata : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      clr_addr  <= '0;
      rsp_valid <= 1'b0;
      for (int i = 0; i < COLORS; i++) begin
        counts[i] <= '0;
      end
    end else begin
      if (cmd.clear) begin
        clr_addr <= clr_addr + BODY_AW'(1);
      end
      if (cmd.eval && add_ok) begin
        counts[fc] <= fc_cnt + CNT_W'(1);
      end else if (cmd.eval && rm_ok) begin
        counts[col_idx] <= rm_last;
      end
      if (cmd.finish) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- hw/rtl/cgca_ctrl.sv -----
// Controller: clearing pass after reset and the per-request sequence.
`timescale 1ns / 1ps

module cgca_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  input  cgca_pkg::ctl_sts_t sts,
  output cgca_pkg::ctl_cmd_t cmd
);
  import cgca_pkg::*;

  localparam logic [1:0] S_CLEAR = 2'd0;
  localparam logic [1:0] S_IDLE  = 2'd1;
  localparam logic [1:0] S_EVAL  = 2'd2;
  localparam logic [1:0] S_FIN   = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  always_comb begin
    state_next = state;
    req_ready  = 1'b0;
    cmd        = '0;
    case (state)
      S_CLEAR: begin
        cmd.clear = 1'b1;
        if (sts.clear_last) begin
          state_next = S_IDLE;
        end
      end
      S_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.accept = 1'b1;
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval   = 1'b1;
        state_next = S_FIN;
      end
      S_FIN: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_CLEAR;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ----- hw/rtl/contact_graph_color_allocator_top.sv -----
// Top level of the contact graph color allocator.
`timescale 1ns / 1ps

// The req channel carries one request word: an add or a remove of a contact
// between two bodies, with the dynamic flags of both bodies. An add places
// the contact in the lowest color in which none of its dynamic bodies is in
// use yet (color 0 only for pairs of two dynamic bodies) and reports color
// and slot. A remove swap-removes a slot of a color's list and reports which
// contact moved into it. The rsp channel returns exactly one word per request.
// On acceptance a request reads both body masks; next it searches and writes
// the first body mask and the list; last it writes the second body mask and
// loads the response register. A new request is taken only after the previous
// one has finished; the single write port of the body mask memory is why,
// since up to two mask entries change per word. After reset, a clearing pass
// zeroes every body mask entry while req ready stays low; the color counts
// clear at once. The contact lists are not cleared. When the receiver stalls,
// the response word waits in its register while the next request is still
// taken and processed up to its last cycle, which then waits until the
// register is free.

module contact_graph_color_allocator_top (
  input logic       clk,
  input logic       rst,
  cgca_req_if.sink  req,
  cgca_rsp_if.source rsp
);
  import cgca_pkg::*;

  ctl_cmd_t     cmd;
  ctl_sts_t     sts;
  logic         req_ready;
  logic         rsp_valid;
  cgca_result_t rsp_data;

  cgca_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req_ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  cgca_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .sts       (sts),
    .req_data  (req.data),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp.ready),
    .rsp_data  (rsp_data)
  );

  assign req.ready = req_ready;
  assign rsp.valid = rsp_valid;
  assign rsp.data  = rsp_data;

endmodule

// ----- hw/rtl/cgca_checker.sv -----
// Port-level assertions for the allocator and the bind that attaches them.
`timescale 1ns / 1ps
`include "contact_graph_color_allocator_top_defines.svh"

module cgca_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_ready,
  input logic                   rsp_valid,
  input logic                   rsp_ready,
  input cgca_pkg::cgca_result_t rsp_data
);
  import cgca_pkg::*;

  // A stalled response word keeps its contents.
  `CGCA_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data), "response word changed while stalled")

  // No request is taken in the cycle after an accepted one.
  `CGCA_ASSERT_NEXT(a_req_spacing, req_valid && req_ready, !req_ready, "request taken in back-to-back cycles")

  // A request that finds no color carries no other information.
  `CGCA_ASSERT_SAME(a_err_zero, rsp_valid && rsp_data.status == ST_NOCOLOR, rsp_data.color_out == '0 && rsp_data.slot_out == '0 && !rsp_data.moved_valid && rsp_data.moved_contact == '0, "error response has nonzero fields")

  // A moved contact is only reported by a successful remove.
  `CGCA_ASSERT_SAME(a_move_ok, rsp_valid && rsp_data.moved_valid, rsp_data.status == ST_OK && rsp_data.color_out == '0 && rsp_data.slot_out == '0, "moved contact on a non-remove response")

endmodule

bind contact_graph_color_allocator_top cgca_checker u_cgca_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_data  (rsp.data)
);
